/* rtl/ptg_pkg.sv */
// shared types and constants of the poisson term generator
package ptg_pkg;

    localparam int MAX_TERMS    = 64;
    localparam int TAYLOR_TERMS = 22;
    localparam int SQUARINGS    = 6;

    localparam logic [31:0] EPS_FLOOR  = 32'd1;
    localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
    localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;
    localparam logic [6:0]  COUNT_RST  = 7'd64;
    localparam logic [6:0]  COUNT_MAX  = 7'(MAX_TERMS);

    // configuration register indexes
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_TERM_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP_MUL,
        S_EXP_DLOAD,
        S_EXP_DIV,
        S_EXP_ACC,
        S_SQ_MUL,
        S_SQ_WB,
        S_TERM0,
        S_EMIT0,
        S_T_MUL,
        S_T_DLOAD,
        S_T_DIV,
        S_T_WB,
        S_T_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_DLOAD,
        OP_DIV,
        OP_TAYLOR_WB,
        OP_SQ_WB,
        OP_TERM0,
        OP_TERM_WB,
        OP_EMIT
    } t_op;

    // multiplier operand pair
    typedef enum logic [1:0] {
        MS_TX,
        MS_EE,
        MS_RT
    } t_msel;

    typedef struct packed {
        t_op        op;
        t_msel      msel;
        logic [2:0] phase;
        logic [5:0] divisor;
        logic       sub;
        logic [5:0] index;
        logic       last;
        logic [6:0] cutoff;
    } t_cmd;

    typedef struct packed {
        logic       below;
        logic       out_busy;
        logic [6:0] count;
    } t_status;

endpackage

/* rtl/ptg_ifs.sv */
// request channels: rate in, poisson term out
interface ptg_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] rate;
    modport source (output valid, output rate, input ready);
    modport sink (input valid, input rate, output ready);
endinterface

interface ptg_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  term_index;
    logic [31:0] term_value;
    logic [6:0]  cutoff;
    logic        last;
    modport source (output valid, output term_index, output term_value, output cutoff,
                    output last, input ready);
    modport sink (input valid, input term_index, input term_value, input cutoff,
                  input last, output ready);
endinterface

/* rtl/ptg_dp.sv */
// datapath: config registers, shared multiplier, divider, term registers, output register
module ptg_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic [23:0]        i_rate,
    input  ptg_pkg::t_cmd      i_cmd,
    output ptg_pkg::t_status   o_status,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [5:0]         o_term_index,
    output logic [31:0]        o_term_value,
    output logic [6:0]         o_cutoff,
    output logic               o_last
);
    logic [31:0]  r_thresh;
    logic [6:0]   r_count;
    logic [23:0]  r_rate;
    logic [63:0]  r_x, r_t, r_e;
    logic [31:0]  r_term;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic [63:0]  r_q;
    logic [5:0]   r_rem;
    logic         r_valid;
    logic [5:0]   r_idx;
    logic [31:0]  r_val;
    logic [6:0]   r_cut;
    logic         r_last;

    logic [63:0]  a, b;
    logic [31:0]  ah, bh;
    logic [127:0] pp_al;
    logic [6:0]   rem2;
    logic         ge;
    logic [31:0]  eff;
    logic [63:0]  rnd;
    logic [6:0]   cnt;

    always_comb begin
        unique case (i_cmd.msel)
            ptg_pkg::MS_EE: begin a = r_e; b = r_e; end
            ptg_pkg::MS_RT: begin a = {40'd0, r_rate}; b = {32'd0, r_term}; end
            default: begin a = r_t; b = r_x; end
        endcase
        ah = i_cmd.phase[1] ? a[63:32] : a[31:0];
        bh = i_cmd.phase[0] ? b[63:32] : b[31:0];
        // align the partial product registered in the previous phase
        unique case (i_cmd.phase)
            3'd1:    pp_al = {64'd0, r_pp};
            3'd2:    pp_al = {32'd0, r_pp, 32'd0};
            3'd3:    pp_al = {32'd0, r_pp, 32'd0};
            3'd4:    pp_al = {r_pp, 64'd0};
            default: pp_al = '0;
        endcase
        rem2 = {r_rem, r_q[63]};
        ge   = rem2 >= {1'b0, i_cmd.divisor};
        eff  = (r_thresh < ptg_pkg::EPS_FLOOR) ? ptg_pkg::EPS_FLOOR : r_thresh;
        rnd  = r_e + 64'h0000_0000_4000_0000;
        if (r_count == 7'd0)
            cnt = 7'd1;
        else if (r_count > ptg_pkg::COUNT_MAX)
            cnt = ptg_pkg::COUNT_MAX;
        else
            cnt = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
            r_count  <= ptg_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptg_pkg::REG_THRESHOLD:  r_thresh <= i_cfg_data;
                ptg_pkg::REG_TERM_COUNT: r_count  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ptg_pkg::OP_LOAD: begin
                r_rate <= i_rate;
                r_x    <= {2'b00, i_rate, 38'd0};
                r_t    <= ptg_pkg::ONE_Q62;
                r_e    <= ptg_pkg::ONE_Q62;
            end
            ptg_pkg::OP_MUL: begin
                if (i_cmd.phase < 3'd4)
                    r_pp <= {32'd0, ah} * {32'd0, bh};
                if (i_cmd.phase == 3'd0)
                    r_acc <= '0;
                else
                    r_acc <= r_acc + pp_al;
            end
            ptg_pkg::OP_DLOAD: begin
                r_rem <= '0;
                if (i_cmd.msel == ptg_pkg::MS_RT)
                    r_q <= r_acc[81:18];
                else
                    r_q <= r_acc[125:62];
            end
            ptg_pkg::OP_DIV: begin
                r_rem <= ge ? 6'(rem2 - {1'b0, i_cmd.divisor}) : rem2[5:0];
                r_q   <= {r_q[62:0], ge};
            end
            ptg_pkg::OP_TAYLOR_WB: begin
                r_t <= r_q;
                r_e <= i_cmd.sub ? r_e - r_q : r_e + r_q;
            end
            ptg_pkg::OP_SQ_WB:   r_e <= r_acc[125:62];
            ptg_pkg::OP_TERM0:   r_term <= rnd[62:31];
            ptg_pkg::OP_TERM_WB: begin
                // saturate a term pushed above one by the rounding of term 0
                r_term <= (r_q > {32'd0, ptg_pkg::ONE_Q31}) ? ptg_pkg::ONE_Q31 : r_q[31:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == ptg_pkg::OP_EMIT) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ptg_pkg::OP_EMIT) begin
            r_idx  <= i_cmd.index;
            r_val  <= r_term;
            r_cut  <= i_cmd.cutoff;
            r_last <= i_cmd.last;
        end
    end

    assign o_status.below    = r_term < eff;
    assign o_status.out_busy = r_valid;
    assign o_status.count    = cnt;
    assign o_valid      = r_valid;
    assign o_term_index = r_idx;
    assign o_term_value = r_val;
    assign o_cutoff     = r_cut;
    assign o_last       = r_last;
endmodule

/* rtl/ptg_ctrl.sv */
// controller: sequences the exponential, squarings and term recurrence
module ptg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptg_pkg::t_status   i_status,
    output ptg_pkg::t_cmd      o_cmd
);
    ptg_pkg::t_state r_state, n_state;
    logic [2:0] r_ph, n_ph;
    logic [5:0] r_bit, n_bit;
    logic [4:0] r_k, n_k;
    logic [2:0] r_sq, n_sq;
    logic [5:0] r_i, n_i;
    logic       at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptg_pkg::S_IDLE;
            r_ph    <= '0;
            r_bit   <= '0;
            r_k     <= '0;
            r_sq    <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_bit   <= n_bit;
            r_k     <= n_k;
            r_sq    <= n_sq;
            r_i     <= n_i;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_bit   = r_bit;
        n_k     = r_k;
        n_sq    = r_sq;
        n_i     = r_i;
        at_end  = ({1'b0, r_i} == i_status.count - 7'd1);
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.op      = ptg_pkg::OP_NONE;
        o_cmd.msel    = ptg_pkg::MS_TX;
        o_cmd.phase   = r_ph;
        o_cmd.divisor = 6'(r_k);
        o_cmd.sub     = r_k[0];
        o_cmd.index   = r_i;
        unique case (r_state)
            ptg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = ptg_pkg::OP_LOAD;
                    n_k      = 5'd1;
                    n_ph     = '0;
                    n_state  = ptg_pkg::S_EXP_MUL;
                end
            end
            ptg_pkg::S_EXP_MUL, ptg_pkg::S_SQ_MUL, ptg_pkg::S_T_MUL: begin
                o_cmd.op   = ptg_pkg::OP_MUL;
                o_cmd.msel = (r_state == ptg_pkg::S_SQ_MUL) ? ptg_pkg::MS_EE :
                             (r_state == ptg_pkg::S_T_MUL)  ? ptg_pkg::MS_RT :
                                                              ptg_pkg::MS_TX;
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd4) begin
                    n_ph = '0;
                    unique case (r_state)
                        ptg_pkg::S_SQ_MUL: n_state = ptg_pkg::S_SQ_WB;
                        ptg_pkg::S_T_MUL:  n_state = ptg_pkg::S_T_DLOAD;
                        default:           n_state = ptg_pkg::S_EXP_DLOAD;
                    endcase
                end
            end
            ptg_pkg::S_EXP_DLOAD, ptg_pkg::S_T_DLOAD: begin
                o_cmd.op   = ptg_pkg::OP_DLOAD;
                o_cmd.msel = (r_state == ptg_pkg::S_T_DLOAD) ? ptg_pkg::MS_RT :
                                                               ptg_pkg::MS_TX;
                n_bit   = '0;
                n_state = (r_state == ptg_pkg::S_T_DLOAD) ? ptg_pkg::S_T_DIV :
                                                            ptg_pkg::S_EXP_DIV;
            end
            ptg_pkg::S_EXP_DIV, ptg_pkg::S_T_DIV: begin
                o_cmd.op      = ptg_pkg::OP_DIV;
                o_cmd.divisor = (r_state == ptg_pkg::S_T_DIV) ? r_i : 6'(r_k);
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'd63)
                    n_state = (r_state == ptg_pkg::S_T_DIV) ? ptg_pkg::S_T_WB :
                                                              ptg_pkg::S_EXP_ACC;
            end
            ptg_pkg::S_EXP_ACC: begin
                o_cmd.op = ptg_pkg::OP_TAYLOR_WB;
                if (r_k == 5'(ptg_pkg::TAYLOR_TERMS)) begin
                    n_sq    = '0;
                    n_state = ptg_pkg::S_SQ_MUL;
                end else begin
                    n_k     = r_k + 5'd1;
                    n_state = ptg_pkg::S_EXP_MUL;
                end
            end
            ptg_pkg::S_SQ_WB: begin
                o_cmd.op = ptg_pkg::OP_SQ_WB;
                if (r_sq == 3'(ptg_pkg::SQUARINGS - 1)) begin
                    n_state = ptg_pkg::S_TERM0;
                end else begin
                    n_sq    = r_sq + 3'd1;
                    n_state = ptg_pkg::S_SQ_MUL;
                end
            end
            ptg_pkg::S_TERM0: begin
                o_cmd.op = ptg_pkg::OP_TERM0;
                n_i      = '0;
                n_state  = ptg_pkg::S_EMIT0;
            end
            ptg_pkg::S_EMIT0: begin
                o_cmd.last   = (i_status.count == 7'd1);
                o_cmd.cutoff = o_cmd.last ? 7'd1 : 7'd0;
                if (!i_status.out_busy) begin
                    o_cmd.op = ptg_pkg::OP_EMIT;
                    n_i      = 6'd1;
                    n_state  = o_cmd.last ? ptg_pkg::S_IDLE : ptg_pkg::S_T_MUL;
                end
            end
            ptg_pkg::S_T_WB: begin
                o_cmd.op = ptg_pkg::OP_TERM_WB;
                n_state  = ptg_pkg::S_T_EMIT;
            end
            ptg_pkg::S_T_EMIT: begin
                o_cmd.last   = i_status.below || at_end;
                o_cmd.cutoff = i_status.below ? {1'b0, r_i} :
                               at_end         ? i_status.count : 7'd0;
                if (!i_status.out_busy) begin
                    o_cmd.op = ptg_pkg::OP_EMIT;
                    n_i      = r_i + 6'd1;
                    n_state  = o_cmd.last ? ptg_pkg::S_IDLE : ptg_pkg::S_T_MUL;
                end
            end
            default: n_state = ptg_pkg::S_IDLE;
        endcase
    end
endmodule

/* rtl/poisson_term_generator.sv */
// top level of the poisson term generator
// a rate request runs 22 taylor steps (each dominated by a radix-2 divide), then six
// squarings, before term 0 is ready
// each later term takes a 4-pass 32x32 multiply plus a radix-2 divide;
// one rate at a time, next rate taken after the last term
// reset: synchronous active low; threshold clears to 0, term_count returns to 64,
// the sequencer idles and the output register empties
module poisson_term_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ptg_in_if.sink      i_in,
    ptg_out_if.source   o_out
);
    ptg_pkg::t_cmd    cmd;
    ptg_pkg::t_status status;

    // sequencer: decides which step the shared units take each cycle
    ptg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: multiplier, divider, exponential and term registers, result register
    ptg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_rate       (i_in.rate),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_term_index (o_out.term_index),
        .o_term_value (o_out.term_value),
        .o_cutoff     (o_out.cutoff),
        .o_last       (o_out.last)
    );
endmodule

/* rtl/ptg_checker.sv */
// port-level checks of the poisson term generator and their binding
module ptg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_term_index,
    input logic [6:0]  i_cutoff,
    input logic        i_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken during a run");

    a_cutoff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_cutoff == 7'd0)
        else $error("cutoff on a non-final term");

    a_cutoff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |->
            i_cutoff == {1'b0, i_term_index} || i_cutoff == {1'b0, i_term_index} + 7'd1)
        else $error("cutoff does not match final index");
endmodule

bind poisson_term_generator ptg_checker u_ptg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_term_index (o_out.term_index),
    .i_cutoff     (o_out.cutoff),
    .i_last       (o_out.last)
);
